### design/fsac_pkg.sv
`default_nettype none

package fsac_pkg;

    localparam int SETS_DEF     = 64;
    localparam int WAYS_DEF     = 4;
    localparam int TAG_BITS_DEF = 32;

    localparam int SET_IN_W   = 6;
    localparam int SET_IN_NUM = 2 ** SET_IN_W;
    localparam int TAG_IN_W   = 32;
    localparam int CFG_W      = 3;
    localparam int WAY_OUT_W  = 2;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = CFG_W'(4);

    // widths sized for the largest way count supported
    localparam int WAYS_MAX  = 16;
    localparam int WAY_W_MAX = $clog2(WAYS_MAX);
    localparam int CNT_W_MAX = $clog2(WAYS_MAX + 1);

    typedef logic [WAY_W_MAX-1:0] way_max_t;
    typedef logic [CNT_W_MAX-1:0] cnt_max_t;

    typedef struct packed {
        logic     hit;
        logic     evict;
        logic     meta_we;
        way_max_t way;
        cnt_max_t fill_next;
        way_max_t oldest_next;
    } decision_t;

endpackage

`default_nettype wire

### design/fsac_if.sv
`default_nettype none

interface fsac_acc_if;
    logic                          valid;
    logic                          ready;
    logic [fsac_pkg::SET_IN_W-1:0] set_index;
    logic [fsac_pkg::TAG_IN_W-1:0] tag;

    modport source (output valid, output set_index, output tag, input ready);
    modport sink   (input valid, input set_index, input tag, output ready);
endinterface

interface fsac_res_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [fsac_pkg::WAY_OUT_W-1:0] way;
    logic                           evicted;
    logic [fsac_pkg::TOTAL_W-1:0]   hit_total;
    logic [fsac_pkg::TOTAL_W-1:0]   miss_total;

    modport source (output valid, output hit, output way, output evicted,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way, input evicted,
                    input hit_total, input miss_total, output ready);
endinterface

interface fsac_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [fsac_pkg::CFG_W-1:0] ways_in_use;

    modport source (output valid, output ways_in_use, input ready);
    modport sink   (input valid, input ways_in_use, output ready);
endinterface

`default_nettype wire

### design/fsac_resolve.sv
`default_nettype none

module fsac_resolve #(
    parameter int WAYS     = fsac_pkg::WAYS_DEF,
    parameter int TAG_BITS = fsac_pkg::TAG_BITS_DEF
) (
    input  wire logic [TAG_BITS-1:0]                       row_tags [WAYS],
    input  wire logic [TAG_BITS-1:0]                       tag,
    input  wire logic [$clog2(WAYS+1)-1:0]                 fill,
    input  wire logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] oldest,
    input  wire logic [$clog2(WAYS+1)-1:0]                 nw,
    output fsac_pkg::decision_t                            dec
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(WAYS + 1);

    logic [CNT_W-1:0] filled;
    logic [CNT_W-1:0] filled_inc;
    logic             room;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] vict;
    logic [CNT_W-1:0] vict_inc;
    logic [WAY_W-1:0] vict_next;
    logic [WAY_W-1:0] way;

    always_comb
    begin
        filled = (fill > nw) ? nw : fill;
        hit     = 1'b0;
        hit_way = '0;
        // lowest matching way wins
        for (int k = WAYS - 1; k >= 0; k--)
        begin
            if ((CNT_W'(k) < filled) && (row_tags[k] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(k);
            end
        end
    end

    assign room       = (filled < nw);
    assign filled_inc = filled + CNT_W'(1);
    assign vict       = (CNT_W'(oldest) >= nw) ? '0 : oldest;
    assign vict_inc   = CNT_W'(vict) + CNT_W'(1);
    assign vict_next  = (vict_inc == nw) ? '0 : WAY_W'(vict_inc);

    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (room)
        begin
            way = WAY_W'(filled);
        end
        else
        begin
            way = vict;
        end
    end

    assign dec.hit         = hit;
    assign dec.evict       = !hit && !room;
    assign dec.meta_we     = !hit;
    assign dec.way         = fsac_pkg::way_max_t'(way);
    assign dec.fill_next   = (!hit && room) ? fsac_pkg::cnt_max_t'(filled_inc)
                                            : fsac_pkg::cnt_max_t'(fill);
    assign dec.oldest_next = (!hit && !room) ? fsac_pkg::way_max_t'(vict_next)
                                             : fsac_pkg::way_max_t'(oldest);

endmodule

`default_nettype wire

### design/fifo_set_assoc_cache_model.sv
// Set-associative tag cache with FIFO replacement. Each access transfer
// (set_index, tag) returns one result: hit/miss, the way hit or filled, whether
// a valid entry was replaced, and saturating hit and miss totals. Accesses are
// handled one at a time: first the synchronous read of the tag and
// fill/pointer memories, then the parallel compare and the write back. A new
// access is taken while the previous result still waits on the result port.
// After reset a clearing pass over all SETS sets zeroes the fill counts and
// pointers, during which no access is taken; ways_in_use writes are taken at
// any time and apply to every lookup resolved after the write.
`default_nettype none

module fifo_set_assoc_cache_model #(
    parameter int SETS     = fsac_pkg::SETS_DEF,
    parameter int WAYS     = fsac_pkg::WAYS_DEF,
    parameter int TAG_BITS = fsac_pkg::TAG_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fsac_acc_if.sink   acc,
    fsac_res_if.source res,
    fsac_cfg_if.sink   cfg
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(WAYS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [SET_W-1:0] clr_idx_reg, clr_idx_next;
    logic [fsac_pkg::CFG_W-1:0] cfg_reg, cfg_next;

    logic [TAG_BITS-1:0] tag_mem  [SETS][WAYS];
    logic [CNT_W-1:0]    fill_mem [SETS];
    logic [WAY_W-1:0]    old_mem  [SETS];

    logic [TAG_BITS-1:0] row_q [WAYS];
    logic [CNT_W-1:0]    fill_q;
    logic [WAY_W-1:0]    old_q;

    logic [SET_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [SET_W-1:0]    set_lut [fsac_pkg::SET_IN_NUM];
    logic [TAG_BITS-1:0] tag_eff;
    logic [CNT_W-1:0]    nw;

    fsac_pkg::decision_t dec;

    logic acc_xfer;
    logic fire;
    logic meta_we;
    logic [SET_W-1:0] meta_addr;
    logic [CNT_W-1:0] meta_fill;
    logic [WAY_W-1:0] meta_old;

    logic out_valid_reg, out_valid_next;
    logic res_hit_reg;
    logic res_evict_reg;
    logic [fsac_pkg::WAY_OUT_W-1:0] res_way_reg;
    logic [fsac_pkg::TOTAL_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [fsac_pkg::TOTAL_W-1:0] miss_cnt_reg, miss_cnt_next;

    for (genvar g = 0; g < fsac_pkg::SET_IN_NUM; g++)
    begin : g_set_lut
        assign set_lut[g] = SET_W'(g % SETS);
    end

    if (TAG_BITS > fsac_pkg::TAG_IN_W)
    begin : g_tag_wide
        assign tag_eff = {{(TAG_BITS - fsac_pkg::TAG_IN_W){1'b0}}, acc.tag};
    end
    else
    begin : g_tag_narrow
        assign tag_eff = acc.tag[TAG_BITS-1:0];
    end

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            nw = CNT_W'(1);
        end
        else if (32'(cfg_reg) > WAYS)
        begin
            nw = CNT_W'(WAYS);
        end
        else
        begin
            nw = CNT_W'(cfg_reg);
        end
    end

    fsac_resolve #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_resolve (
        .row_tags (row_q),
        .tag      (tag_reg),
        .fill     (fill_q),
        .oldest   (old_q),
        .nw       (nw),
        .dec      (dec)
    );

    assign acc.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign acc_xfer  = acc.valid && acc.ready;
    assign fire      = (state_reg == ST_LOOK) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign cfg_next = cfg.valid ? cfg.ways_in_use : cfg_reg;

    assign hit_cnt_next  = (fire && dec.hit && (hit_cnt_reg != '1))
                         ? hit_cnt_reg + fsac_pkg::TOTAL_W'(1) : hit_cnt_reg;
    assign miss_cnt_next = (fire && !dec.hit && (miss_cnt_reg != '1))
                         ? miss_cnt_reg + fsac_pkg::TOTAL_W'(1) : miss_cnt_reg;

    assign out_valid_next = fire ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            cfg_reg       <= fsac_pkg::WAYS_IN_USE_RST;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_xfer)
        begin
            set_reg <= set_lut[acc.set_index];
            tag_reg <= tag_eff;
        end
        if (fire)
        begin
            res_hit_reg   <= dec.hit;
            res_evict_reg <= dec.evict;
            res_way_reg   <= dec.way[fsac_pkg::WAY_OUT_W-1:0];
        end
    end

    // tag memory: row read, single-way write
    always_ff @(posedge clk)
    begin
        if (acc_xfer)
        begin
            row_q <= tag_mem[set_lut[acc.set_index]];
        end
        if (fire && !dec.hit)
        begin
            tag_mem[set_reg][dec.way[WAY_W-1:0]] <= tag_reg;
        end
    end

    assign meta_we   = (state_reg == ST_CLEAR) || (fire && dec.meta_we);
    assign meta_addr = (state_reg == ST_CLEAR) ? clr_idx_reg : set_reg;
    assign meta_fill = (state_reg == ST_CLEAR) ? '0 : dec.fill_next[CNT_W-1:0];
    assign meta_old  = (state_reg == ST_CLEAR) ? '0 : dec.oldest_next[WAY_W-1:0];

    // fill count / oldest pointer memory
    always_ff @(posedge clk)
    begin
        if (acc_xfer)
        begin
            fill_q <= fill_mem[set_lut[acc.set_index]];
            old_q  <= old_mem[set_lut[acc.set_index]];
        end
        if (meta_we)
        begin
            fill_mem[meta_addr] <= meta_fill;
            old_mem[meta_addr]  <= meta_old;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.hit        = res_hit_reg;
    assign res.way        = res_way_reg;
    assign res.evicted    = res_evict_reg;
    assign res.hit_total  = hit_cnt_reg;
    assign res.miss_total = miss_cnt_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_rise_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOK))
        else $error("result appeared without a lookup");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> !((hit_cnt_reg != $past(hit_cnt_reg))
                   && (miss_cnt_reg != $past(miss_cnt_reg))))
        else $error("hit and miss totals moved together");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_hit_reg |-> !res_evict_reg)
        else $error("hit flagged as eviction");

endmodule

`default_nettype wire
